// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line frame validator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/lfv_pkg.sv
// ----------------------------------------------------------------------------
// Line frame validator package
// Shared types, status codes and constant tables of the line frame validator.
// ----------------------------------------------------------------------------
package lfv_pkg;

   // Verdict and payload status codes.
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StTooLong   = 3'd1;
   localparam logic [2:0] StEmpty     = 3'd2;
   localparam logic [2:0] StForbidden = 3'd3;
   localparam logic [2:0] StHeader    = 3'd4;
   localparam logic [2:0] StBadUtf8   = 3'd5;
   localparam logic [2:0] StTruncated = 3'd6;
   localparam logic [2:0] StCleanEnd  = 3'd7;

   // Header match phases: 0 skips blanks, 1..14 letters matched.
   localparam logic [4:0] HdrStart = 5'd0;
   localparam logic [4:0] HdrColon = 5'd14;
   localparam logic [4:0] HdrFound = 5'd15;
   localparam logic [4:0] HdrNone  = 5'd16;

   // UTF-8 decoder states.
   localparam logic [2:0] U8Lead    = 3'd0;
   localparam logic [2:0] U8One     = 3'd1;
   localparam logic [2:0] U8Two     = 3'd2;
   localparam logic [2:0] U8AfterE0 = 3'd3;
   localparam logic [2:0] U8AfterED = 3'd4;
   localparam logic [2:0] U8Three   = 3'd5;
   localparam logic [2:0] U8AfterF0 = 3'd6;
   localparam logic [2:0] U8AfterF4 = 3'd7;

   // Special characters.
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChCr      = 8'h0D;
   localparam logic [7:0] ChNul     = 8'h00;
   localparam logic [7:0] ChColon   = 8'h3A;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChTab     = 8'h09;

   // Limit register value after reset, before truncation to the length width.
   localparam int unsigned LimitResetValue = 1048576;

   // Depth of the queue between front and back.
   localparam int unsigned QueueDepth = 2;

   // One classified word as it travels from front to back.
   typedef struct packed {
      logic       eos;
      logic       newline;
      logic       forbidden;
      logic       blank;
      logic       colon;
      logic [7:0] data;
      logic [7:0] lower;
      logic [2:0] lead_next;
      logic       lead_bad;
   } lfv_item_type;

   // Letters of the header name, lower case.
   function automatic logic [7:0] hdr_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "c";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "l";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/lfv_front.sv
// ----------------------------------------------------------------------------
// Line frame validator front
// Classifies each incoming word into the flags the back end needs.
// ----------------------------------------------------------------------------
module lfv_front (
   input  logic                 in_end_of_stream,
   input  logic [7:0]           in_byte,
   output lfv_pkg::lfv_item_type item
);
   import lfv_pkg::*;

   // Byte flags, case folding and the UTF-8 lead byte decode.
   always_comb begin
      item.eos       = in_end_of_stream;
      item.data      = in_byte;
      item.newline   = (in_byte == ChNewline);
      item.forbidden = (in_byte == ChCr) || (in_byte == ChNul);
      item.blank     = (in_byte == ChSpace) || (in_byte == ChTab);
      item.colon     = (in_byte == ChColon);
      item.lower     = ((in_byte >= "A") && (in_byte <= "Z")) ? (in_byte + 8'd32) : in_byte;
      item.lead_bad  = 1'b0;
      if (in_byte <= 8'h7F) begin
         item.lead_next = U8Lead;
      end else if ((in_byte >= 8'hC2) && (in_byte <= 8'hDF)) begin
         item.lead_next = U8One;
      end else if (in_byte == 8'hE0) begin
         item.lead_next = U8AfterE0;
      end else if (in_byte == 8'hED) begin
         item.lead_next = U8AfterED;
      end else if ((in_byte >= 8'hE1) && (in_byte <= 8'hEF)) begin
         item.lead_next = U8Two;
      end else if (in_byte == 8'hF0) begin
         item.lead_next = U8AfterF0;
      end else if ((in_byte >= 8'hF1) && (in_byte <= 8'hF3)) begin
         item.lead_next = U8Three;
      end else if (in_byte == 8'hF4) begin
         item.lead_next = U8AfterF4;
      end else begin
         item.lead_next = U8Lead;
         item.lead_bad  = 1'b1;
      end
   end

endmodule

// File: rtl/lfv_queue.sv
// ----------------------------------------------------------------------------
// Line frame validator queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module lfv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lfv_pkg::lfv_item_type push_item,
   input  logic                  pop,
   output lfv_pkg::lfv_item_type head_item,
   output logic                  not_empty,
   output logic                  full
);
   import lfv_pkg::*;

   localparam int PtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountBits = $clog2(QueueDepth + 1);

   lfv_item_type         slot_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CountBits'(QueueDepth));
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/lfv_back.sv
// ----------------------------------------------------------------------------
// Line frame validator back
// Tracks frame state, passes payload words and gives the verdict of a frame.
// ----------------------------------------------------------------------------
module lfv_back #(
   parameter int LENGTH_BITS = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LENGTH_BITS-1:0] max_frame_length,
   input  logic                   item_valid,
   input  lfv_pkg::lfv_item_type  item,
   output logic                   item_pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_end,
   output logic [2:0]             rsp_status
);
   import lfv_pkg::*;

   logic [LENGTH_BITS-1:0] frame_len_ff, frame_len_in;
   logic                   discard_ff, discard_in;
   logic                   forbid_ff, forbid_in;
   logic [4:0]             hdr_ff, hdr_in;
   logic [2:0]             u8_ff, u8_in;
   logic                   u8_err_ff, u8_err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_end_ff, rsp_end_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic                   fire;
   logic                   emit;
   logic [7:0]             cont_lo;
   logic [7:0]             cont_hi;
   logic [2:0]             cont_next;

   // A word is taken whenever the output register is free or draining.
   assign fire     = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign item_pop = fire;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;

   // Allowed continuation range for the pending UTF-8 sequence.
   always_comb begin
      cont_lo   = 8'h80;
      cont_hi   = 8'hBF;
      cont_next = U8Lead;
      case (u8_ff)
         U8One:     cont_next = U8Lead;
         U8Two:     cont_next = U8One;
         U8AfterE0: begin
            cont_lo   = 8'hA0;
            cont_next = U8One;
         end
         U8AfterED: begin
            cont_hi   = 8'h9F;
            cont_next = U8One;
         end
         U8Three:   cont_next = U8Two;
         U8AfterF0: begin
            cont_lo   = 8'h90;
            cont_next = U8Two;
         end
         U8AfterF4: begin
            cont_hi   = 8'h8F;
            cont_next = U8Two;
         end
         default: begin
            cont_lo   = 8'h01;
            cont_hi   = 8'h00;
            cont_next = U8Lead;
         end
      endcase
   end

   // Frame state update and result selection for the word at the queue head.
   always_comb begin
      frame_len_in  = frame_len_ff;
      discard_in    = discard_ff;
      forbid_in     = forbid_ff;
      hdr_in        = hdr_ff;
      u8_in         = u8_ff;
      u8_err_in     = u8_err_ff;
      emit          = 1'b0;
      rsp_byte_in   = 8'h00;
      rsp_end_in    = 1'b1;
      rsp_status_in = StOk;
      if (item.eos || item.newline) begin
         emit = 1'b1;
         if (item.eos) begin
            rsp_status_in = ((frame_len_ff != '0) || discard_ff) ? StTruncated : StCleanEnd;
         end else if (discard_ff) begin
            rsp_status_in = StTooLong;
         end else if (frame_len_ff == '0) begin
            rsp_status_in = StEmpty;
         end else if (forbid_ff) begin
            rsp_status_in = StForbidden;
         end else if (hdr_ff == HdrFound) begin
            rsp_status_in = StHeader;
         end else if (u8_err_ff || (u8_ff != U8Lead)) begin
            rsp_status_in = StBadUtf8;
         end
         frame_len_in = '0;
         discard_in   = 1'b0;
         forbid_in    = 1'b0;
         hdr_in       = HdrStart;
         u8_in        = U8Lead;
         u8_err_in    = 1'b0;
      end else if (discard_ff) begin
         emit = 1'b0;
      end else if (frame_len_ff >= max_frame_length) begin
         discard_in = 1'b1;
      end else begin
         emit         = 1'b1;
         rsp_byte_in  = item.data;
         rsp_end_in   = 1'b0;
         frame_len_in = frame_len_ff + 1'b1;
         forbid_in    = forbid_ff || item.forbidden;
         // Header name match, case-insensitive, after leading blanks.
         if (hdr_ff == HdrStart) begin
            if (!item.blank) begin
               hdr_in = (item.lower == hdr_char(4'd0)) ? 5'd1 : HdrNone;
            end
         end else if (hdr_ff < HdrColon) begin
            hdr_in = (item.lower == hdr_char(hdr_ff[3:0])) ? (hdr_ff + 5'd1) : HdrNone;
         end else if (hdr_ff == HdrColon) begin
            hdr_in = item.colon ? HdrFound : HdrNone;
         end else if (hdr_ff != HdrFound) begin
            hdr_in = HdrNone;
         end
         // Strict UTF-8 decoding.
         if (u8_ff == U8Lead) begin
            u8_in     = item.lead_next;
            u8_err_in = u8_err_ff || item.lead_bad;
         end else if ((item.data < cont_lo) || (item.data > cont_hi)) begin
            u8_in     = U8Lead;
            u8_err_in = 1'b1;
         end else begin
            u8_in = cont_next;
         end
      end
   end

   // The output register loads on a result and empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= '0;
         discard_ff   <= 1'b0;
         forbid_ff    <= 1'b0;
         hdr_ff       <= HdrStart;
         u8_ff        <= U8Lead;
         u8_err_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            frame_len_ff <= frame_len_in;
            discard_ff   <= discard_in;
            forbid_ff    <= forbid_in;
            hdr_ff       <= hdr_in;
            u8_ff        <= u8_in;
            u8_err_ff    <= u8_err_in;
         end
      end
   end

   // Result payload holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

// File: rtl/line_frame_validator_unit.sv
// ----------------------------------------------------------------------------
// Line frame validator unit
// Cuts a byte stream into newline-terminated frames and judges each frame.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one word per stream byte, or an end-of-stream
// marker. Each payload byte within the frame limit comes back as one rsp_
// word with rsp_frame_end low. A newline returns one verdict word with
// rsp_frame_end high and the frame status; bytes beyond the limit give no
// word. An end-of-stream marker returns truncated or clean end.
// The csr_ channel writes the frame length limit; it is always ready. The user
// must write it only while the unit is idle; the block does not enforce this.
// A word is held in a queue slot register, and its result in the output
// register. Throughput: one word per cycle while rsp_stall is low; a
// two-entry queue separates the classifier from the back end.
// When rsp_stall holds, the output register keeps its word, the queue fills
// and req_stall rises once it is full.
// Reset clears the queue, the frame state and the output register, and sets
// the limit to 1048576 taken in LENGTH_BITS bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_frame_validator_unit #(
   parameter int LENGTH_BITS = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_end_of_stream,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_end,
   output logic [2:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LENGTH_BITS-1:0] csr_max_frame_length
);
   import lfv_pkg::*;

   localparam logic [LENGTH_BITS-1:0] LimitReset = LENGTH_BITS'(LimitResetValue);

   logic [LENGTH_BITS-1:0] limit_ff;
   lfv_item_type           front_item;
   lfv_item_type           head_item;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   logic                   q_full;

   // Limit register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_max_frame_length;
      end
   end

   // Front: classify each accepted word.
   lfv_front u_front (
      .in_end_of_stream (req_end_of_stream),
      .in_byte          (req_in_byte),
      .item             (front_item)
   );

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall;

   lfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Back: frame state and result output register.
   lfv_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .max_frame_length (limit_ff),
      .item_valid       (q_not_empty),
      .item             (head_item),
      .item_pop         (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status)
   );

   // Checks on the design's own logic.
   `ASSERT_ALWAYS(a_no_pop_into_stalled_word, clock, reset,
      !(q_pop && rsp_valid && rsp_stall), "back end took a word while the held result was stalled")
   `ASSERT_IMPLIES(a_verdict_byte_zero, clock, reset, rsp_valid && rsp_frame_end,
      rsp_out_byte == 8'h00, "verdict word carries a nonzero byte")
   `ASSERT_IMPLIES(a_payload_status_ok, clock, reset, rsp_valid && !rsp_frame_end,
      rsp_status == StOk, "payload word carries a nonzero status")

endmodule

// File: tb/sv/lfv_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line frame validator checker
// Watches the request, response and register channels of the validator,
// predicts every response word from the accepted request words and compares
// each accepted response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lfv_frame_checker #(
   parameter int LENGTH_BITS = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_end_of_stream,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [7:0]             rsp_out_byte,
   input  logic                   rsp_frame_end,
   input  logic [2:0]             rsp_status,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [LENGTH_BITS-1:0] csr_max_frame_length,
   output int                     fail_count,
   output int                     outstanding
);
   import lfv_pkg::*;

   // Header name, lower case, first letter in the top byte.
   localparam logic [8*14-1:0] HeaderText = "content-length";

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [2:0] status;
   } frame_word_type;

   frame_word_type expected_words[$];

   // Frame state as the validator should hold it.
   logic [LENGTH_BITS-1:0] frame_limit;
   logic [LENGTH_BITS-1:0] open_length;
   logic                   dropping;
   logic                   saw_ctrl;
   logic [4:0]             header_phase;
   logic [2:0]             utf8_state;
   logic                   utf8_bad;

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Appends one predicted word at the tail of the queue.
   task automatic expect_word(input frame_word_type w);
      expected_words.insert(expected_words.size(), w);
   endtask

   task automatic restart_frame();
      open_length  = '0;
      dropping     = 1'b0;
      saw_ctrl     = 1'b0;
      header_phase = HdrStart;
      utf8_state   = U8Lead;
      utf8_bad     = 1'b0;
   endtask

   // Header scan: blanks are skipped, then the name is matched without
   // regard to case, then a colon must follow at once.
   task automatic scan_header(input logic [7:0] b);
      logic [7:0] low;
      low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (header_phase == HdrStart) begin
         if (b != ChSpace && b != ChTab)
            header_phase = (low == HeaderText[8*13 +: 8]) ? 5'd1 : HdrNone;
      end else if (header_phase < HdrColon) begin
         if (low == HeaderText[8 * (13 - int'(header_phase)) +: 8])
            header_phase = header_phase + 5'd1;
         else
            header_phase = HdrNone;
      end else if (header_phase == HdrColon) begin
         header_phase = (b == ChColon) ? HdrFound : HdrNone;
      end else if (header_phase != HdrFound) begin
         header_phase = HdrNone;
      end
   endtask

   // Strict UTF-8 decoding; the second byte after E0, ED, F0 and F4 has a
   // narrowed range to reject overlong forms, surrogates and values past
   // the last code point.
   task automatic decode_utf8(input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [2:0] nxt;
      if (utf8_state == U8Lead) begin
         if (b <= 8'h7F)                      utf8_state = U8Lead;
         else if (b >= 8'hC2 && b <= 8'hDF)   utf8_state = U8One;
         else if (b == 8'hE0)                 utf8_state = U8AfterE0;
         else if (b == 8'hED)                 utf8_state = U8AfterED;
         else if (b >= 8'hE1 && b <= 8'hEF)   utf8_state = U8Two;
         else if (b == 8'hF0)                 utf8_state = U8AfterF0;
         else if (b >= 8'hF1 && b <= 8'hF3)   utf8_state = U8Three;
         else if (b == 8'hF4)                 utf8_state = U8AfterF4;
         else begin
            utf8_bad   = 1'b1;
            utf8_state = U8Lead;
         end
      end else begin
         lo = 8'h80;
         hi = 8'hBF;
         case (utf8_state)
            U8One:     nxt = U8Lead;
            U8Two:     nxt = U8One;
            U8AfterE0: begin
               lo  = 8'hA0;
               nxt = U8One;
            end
            U8AfterED: begin
               hi  = 8'h9F;
               nxt = U8One;
            end
            U8Three:   nxt = U8Two;
            U8AfterF0: begin
               lo  = 8'h90;
               nxt = U8Two;
            end
            U8AfterF4: begin
               hi  = 8'h8F;
               nxt = U8Two;
            end
            default:   nxt = U8Lead;
         endcase
         if (b < lo || b > hi) begin
            utf8_bad = 1'b1;
            nxt      = U8Lead;
         end
         utf8_state = nxt;
      end
   endtask

   // Works out the response word, if any, of one accepted request word.
   task automatic judge_word(input logic [7:0] b, input logic eos);
      frame_word_type w;
      w.out_byte  = 8'h00;
      w.frame_end = 1'b1;
      w.status    = StOk;
      if (eos) begin
         w.status = (open_length != 0 || dropping) ? StTruncated : StCleanEnd;
         restart_frame();
         expect_word(w);
      end else if (b == ChNewline) begin
         if (dropping)                            w.status = StTooLong;
         else if (open_length == 0)               w.status = StEmpty;
         else if (saw_ctrl)                       w.status = StForbidden;
         else if (header_phase == HdrFound)       w.status = StHeader;
         else if (utf8_bad || utf8_state != U8Lead) w.status = StBadUtf8;
         restart_frame();
         expect_word(w);
      end else if (!dropping) begin
         // The first byte past the limit switches the frame to dropping.
         if (open_length >= frame_limit) begin
            dropping = 1'b1;
         end else begin
            open_length = open_length + 1'b1;
            if (b == ChCr || b == ChNul)
               saw_ctrl = 1'b1;
            scan_header(b);
            decode_utf8(b);
            w.out_byte  = b;
            w.frame_end = 1'b0;
            expect_word(w);
         end
      end
   endtask

   // Responses are checked before the request of the same edge is added,
   // since a request cannot be answered in the cycle it is taken.
   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         expected_words.delete();
         frame_limit = LENGTH_BITS'(LimitResetValue);
         restart_frame();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word byte %02h end %0b status %0d",
                                         rsp_out_byte, rsp_frame_end, rsp_status));
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %0b, expected %0b",
                                            rsp_frame_end, want.frame_end));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && !req_stall)
            judge_word(req_in_byte, req_end_of_stream);
         if (csr_valid && csr_ready)
            frame_limit = csr_max_frame_length;
         outstanding <= expected_words.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line frame validator testbench
// Feeds directed frames and then random frames of text, multi-byte UTF-8,
// headers, broken sequences, control bytes and raw noise under several
// frame limits, with random gaps on both sides; the checker predicts and
// compares every response word.
// ----------------------------------------------------------------------------
module tb_top;
   import lfv_pkg::*;

   localparam int LengthBits    = 21;
   localparam int IdleLimit     = 2000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles   = QueueDepth + 3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_in_byte;
   logic                  req_end_of_stream;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_frame_end;
   logic [2:0]            rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LengthBits-1:0] csr_max_frame_length;

   int fail_count;
   int outstanding;
   int idle_cycles;
   int phase_words;

   // Idling controls for the sender and the receiver.
   logic req_idle_on = 1'b0;
   logic rsp_idle_on = 1'b0;
   logic long_hold   = 1'b0;

   // Words of the frame being built; bit 8 marks end of stream.
   logic [8:0] frame_words[$];

   line_frame_validator_unit #(
      .LENGTH_BITS(LengthBits)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length)
   );

   lfv_frame_checker #(
      .LENGTH_BITS(LengthBits)
   ) frame_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ends the run once nothing has been accepted on any channel for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: stalls a random number of cycles before each word, or one
   // long stretch on request so that the validator backs up.
   initial begin
      int hold;
      forever begin
         if (long_hold) begin
            hold      = HoldOffCycles;
            long_hold = 1'b0;
         end else begin
            hold = rsp_idle_on ? $urandom_range(0, 18) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_word(input logic [8:0] w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= w[7:0];
      req_end_of_stream <= w[8];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      phase_words++;
   endtask

   task automatic send_frame();
      foreach (frame_words[i])
         send_word(frame_words[i]);
      frame_words.delete();
   endtask

   // Adds one word at the end of the frame being built.
   task automatic append_word(input logic [8:0] w);
      frame_words.insert(frame_words.size(), w);
   endtask

   task automatic push_byte(input logic [7:0] b);
      append_word({1'b0, b});
   endtask

   // Waits for every predicted word, then for bytes that are being dropped
   // and give no word to clear the validator.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LengthBits-1:0] value);
      drain();
      csr_valid            <= 1'b1;
      csr_max_frame_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Class 0 is plain ASCII, 1 to 3 are two to four byte forms, and the
   // rest picks a code point at the edge of a range.
   task automatic push_code_point(input int cls);
      logic [20:0] cp;
      case (cls)
         0: begin
            cp = 21'($urandom_range(1, 'h7F));
            if (cp == 21'(ChNewline) || cp == 21'(ChCr))
               cp = 21'("~");
         end
         1: cp = 21'($urandom_range('h80, 'h7FF));
         2: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
               cp = cp - 21'h800;
         end
         3: cp = 21'($urandom_range('h10000, 'h10FFFF));
         default: begin
            case ($urandom_range(0, 7))
               0:       cp = 21'h80;
               1:       cp = 21'h7FF;
               2:       cp = 21'h800;
               3:       cp = 21'hD7FF;
               4:       cp = 21'hE000;
               5:       cp = 21'hFFFF;
               6:       cp = 21'h10000;
               default: cp = 21'h10FFFF;
            endcase
         end
      endcase
      if (cp < 21'h80) begin
         push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         push_byte({3'b110, cp[10:6]});
         push_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         push_byte({4'b1110, cp[15:12]});
         push_byte({2'b10, cp[11:6]});
         push_byte({2'b10, cp[5:0]});
      end else begin
         push_byte({5'b11110, cp[20:18]});
         push_byte({2'b10, cp[17:12]});
         push_byte({2'b10, cp[11:6]});
         push_byte({2'b10, cp[5:0]});
      end
   endtask

   // A lead byte that is never valid, a lone continuation, or a lead byte
   // followed by continuations that may fall outside its range.
   task automatic push_broken_sequence();
      case ($urandom_range(0, 4))
         0: push_byte(8'($urandom_range('hF5, 'hFF)));
         1: push_byte(8'($urandom_range('hC0, 'hC1)));
         2: push_byte(8'($urandom_range('h80, 'hBF)));
         3: begin
            case ($urandom_range(0, 3))
               0:       push_byte(8'hE0);
               1:       push_byte(8'hED);
               2:       push_byte(8'hF0);
               default: push_byte(8'hF4);
            endcase
         end
         default: push_byte(8'($urandom_range('hC2, 'hF4)));
      endcase
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0)
            push_byte(8'($urandom_range('h20, 'h7E)));
         else
            push_byte(8'($urandom_range('h7F, 'hC1)));
      end
   endtask

   // Header line: optional blanks, the name in mixed case, sometimes cut
   // short or with a wrong letter, then a colon or a stray character.
   task automatic push_header();
      int cut;
      logic [7:0] ch;
      repeat ($urandom_range(0, 3))
         push_byte($urandom_range(0, 1) ? ChSpace : ChTab);
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 13) : 14;
      for (int k = 0; k < cut; k++) begin
         ch = hdr_char(k[3:0]);
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1)
            ch = ch - 8'd32;
         if ($urandom_range(0, 19) == 0)
            ch = 8'($urandom_range('h21, 'h7E));
         push_byte(ch);
      end
      if (cut == 14) begin
         if ($urandom_range(0, 4) == 0)
            push_byte(8'($urandom_range('h21, 'h7E)));
         else
            push_byte(ChColon);
      end
      push_byte(ChSpace);
      repeat ($urandom_range(1, 4))
         push_byte(8'h30 + 8'($urandom_range(0, 9)));
   endtask

   // Builds one random frame of up to about span payload bytes.
   task automatic compose_frame(input int span);
      int n;
      n = $urandom_range(0, span);
      case ($urandom_range(0, 9))
         0, 1, 2: repeat (n) push_code_point(0);
         3, 4:    repeat (n) push_code_point($urandom_range(0, 4));
         5:       push_header();
         6: begin
            repeat ($urandom_range(0, 3)) push_code_point($urandom_range(0, 4));
            push_broken_sequence();
            if ($urandom_range(0, 1) == 1)
               repeat ($urandom_range(1, 3)) push_code_point($urandom_range(0, 4));
         end
         7:       repeat (n) push_byte(8'($urandom_range(0, 255)));
         8:       ;  // empty line
         default: begin
            repeat (n) push_code_point(0);
            push_byte($urandom_range(0, 1) ? ChCr : ChNul);
            repeat ($urandom_range(0, 3)) push_code_point(0);
         end
      endcase
      // A late control byte sometimes joins a frame of any kind.
      if ($urandom_range(0, 9) == 0)
         push_byte($urandom_range(0, 1) ? ChCr : ChNul);
      case ($urandom_range(0, 19))
         0, 1:    append_word({1'b1, 8'($urandom_range(0, 255))});
         2:       ;  // runs on into the next frame
         default: push_byte(ChNewline);
      endcase
   endtask

   task automatic run_frames(input int span, input int quota);
      phase_words = 0;
      while (phase_words < quota) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         compose_frame(span);
         send_frame();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_in_byte          <= 8'h00;
      req_end_of_stream    <= 1'b0;
      csr_valid            <= 1'b0;
      csr_max_frame_length <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty line, clean end, NUL, invalid lead byte, truncation
      // and a header behind a tab, all under the reset limit.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      push_byte(ChNewline);
      append_word({1'b1, 8'h00});
      push_byte(ChNul);
      push_byte(ChNewline);
      push_byte(8'hFF);
      push_byte(ChNewline);
      push_byte("a");
      append_word({1'b1, 8'hFF});
      push_byte(ChTab);
      for (int k = 0; k < 14; k++)
         push_byte((k % 2 == 0 && hdr_char(k[3:0]) != "-") ?
                   hdr_char(k[3:0]) - 8'd32 : hdr_char(k[3:0]));
      push_byte(ChColon);
      push_byte(ChNewline);
      send_frame();

      // Back-pressure: the receiver holds off while words keep coming, then
      // the sender waits until every word has come back.
      long_hold   = 1'b1;
      req_idle_on = 1'b0;
      repeat (4) begin
         repeat (9) push_code_point(0);
         push_byte(ChNewline);
      end
      send_frame();
      drain();

      run_frames(20, 230);
      write_limit(21'd1);
      run_frames(3, 100);
      write_limit(21'd0);
      run_frames(3, 80);
      write_limit('1);
      run_frames(24, 150);
      write_limit(21'd8);
      run_frames(14, 180);
      write_limit(21'd16);
      run_frames(24, 180);
      write_limit(LengthBits'($urandom_range(2, 40)));
      run_frames(48, 180);
      write_limit(LengthBits'(LimitResetValue));
      run_frames(30, 150);

      drain();
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lfv_pkg.sv
rtl/lfv_front.sv
rtl/lfv_queue.sv
rtl/lfv_back.sv
rtl/line_frame_validator_unit.sv
tb/sv/lfv_frame_checker.sv
tb/sv/tb_top.sv
